// File: rtl/bta_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary table arc consistency package
// Shared field widths and the add command that the sequencer sends to the
// cells of the relation chain.
// ----------------------------------------------------------------------------
package bta_pkg;

  localparam int IDX_W = 4;
  localparam int DOM_W = 16;
  localparam int CMP_W = 7;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_FILTER = 1'b1;

  typedef struct packed {
    logic en;
    logic x_any;
    logic [IDX_W-1:0] x_index;
    logic y_any;
    logic [IDX_W-1:0] y_index;
  } add_cmd_t;

endpackage

// File: rtl/bta_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Relation row cell
// Holds one row of the relation matrix. The row moves to the neighbor cell
// on every shift cycle and takes add commands aimed at its home row index.
// ----------------------------------------------------------------------------
module bta_cell #(
  parameter int WIDTH = 16,
  parameter int ROW_INDEX = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic shift,
  input  bta_pkg::add_cmd_t add_cmd,
  input  logic [WIDTH-1:0] row_in,
  output logic [WIDTH-1:0] row_out
);

  logic [WIDTH-1:0] row;
  logic [WIDTH-1:0] set_bits;
  logic hit;

  always_comb begin
    for (int b = 0; b < WIDTH; b++) begin
      set_bits[b] = add_cmd.y_any ||
                    (bta_pkg::CMP_W'(add_cmd.y_index) == bta_pkg::CMP_W'(b));
    end
  end

  assign hit = add_cmd.en &&
               (add_cmd.x_any ||
                bta_pkg::CMP_W'(add_cmd.x_index) == bta_pkg::CMP_W'(ROW_INDEX));

  always_ff @(posedge clk) begin
    if (rst) begin
      row <= '0;
    end else if (shift) begin
      row <= row_in;
    end else if (hit) begin
      row <= row | set_bits;
    end
  end

  assign row_out = row;

endmodule

// File: rtl/bta_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Filter sequencer
// Takes input transactions, issues add commands to the cells, rotates the
// relation rows past the head cell for the x and y passes, and holds the
// result register of the output channel.
// ----------------------------------------------------------------------------
module bta_seq #(
  parameter int DOMAIN_SIZE = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic support_mode,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic [bta_pkg::IDX_W-1:0] x_index,
  input  logic [bta_pkg::IDX_W-1:0] y_index,
  input  logic x_any,
  input  logic y_any,
  input  logic [bta_pkg::DOM_W-1:0] x_domain,
  input  logic [bta_pkg::DOM_W-1:0] y_domain,
  input  logic [DOMAIN_SIZE-1:0] head_row,
  output logic shift,
  output bta_pkg::add_cmd_t add_cmd,
  output logic out_valid,
  input  logic out_stall,
  output logic [bta_pkg::DOM_W-1:0] x_domain_out,
  output logic [bta_pkg::DOM_W-1:0] y_domain_out,
  output logic wiped_out,
  output logic entailed
);

  localparam int D = DOMAIN_SIZE;
  localparam int CW = $clog2(DOMAIN_SIZE);
  localparam int NB = (DOMAIN_SIZE < bta_pkg::DOM_W) ? DOMAIN_SIZE : bta_pkg::DOM_W;

  typedef enum logic [1:0] {IDLE, XPASS, YPASS, FINISH} state_t;

  state_t state;
  logic [CW-1:0] cnt;
  logic [D-1:0] xd;
  logic [D-1:0] yd;
  logic [D-1:0] res_x;
  logic [D-1:0] res_y;
  logic [D-1:0] acc;
  logic res_wipe;
  logic res_ent;
  logic one_pass;

  logic accept;
  logic last;
  logic [D-1:0] xm;
  logic [D-1:0] ym;
  logic x_single;
  logic y_single;
  logic partner;
  logic [D-1:0] keep_next;
  logic [D-1:0] acc_next;
  logic [D-1:0] y_final;
  logic out_free;
  logic [bta_pkg::DOM_W-1:0] x_port;
  logic [bta_pkg::DOM_W-1:0] y_port;

  assign in_stall = (state != IDLE);
  assign accept = in_valid && !in_stall;
  assign shift = (state == XPASS) || (state == YPASS);
  assign last = (cnt == CW'(D - 1));
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    xm = '0;
    ym = '0;
    x_port = '0;
    y_port = '0;
    for (int b = 0; b < NB; b++) begin
      xm[b] = x_domain[b];
      ym[b] = y_domain[b];
      x_port[b] = res_x[b];
      y_port[b] = res_y[b];
    end
  end

  assign x_single = (xm != '0) && ((xm & (xm - D'(1))) == '0);
  assign y_single = (ym != '0) && ((ym & (ym - D'(1))) == '0);

  assign add_cmd.en = accept && (op == bta_pkg::OP_ADD) &&
                      (x_any || bta_pkg::CMP_W'(x_index) < bta_pkg::CMP_W'(D)) &&
                      (y_any || bta_pkg::CMP_W'(y_index) < bta_pkg::CMP_W'(D));
  assign add_cmd.x_any = x_any;
  assign add_cmd.x_index = x_index;
  assign add_cmd.y_any = y_any;
  assign add_cmd.y_index = y_index;

  assign partner = support_mode ? ((head_row & yd) != '0) : ((~head_row & yd) != '0);
  assign keep_next = res_x | (D'(xd[cnt] && partner) << cnt);
  assign acc_next = res_x[cnt] ? (acc | (support_mode ? head_row : ~head_row)) : acc;
  assign y_final = yd & acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept && op == bta_pkg::OP_FILTER) begin
            xd <= xm;
            yd <= ym;
            res_y <= ym;
            acc <= '0;
            res_wipe <= 1'b0;
            res_ent <= 1'b0;
            if (xm == '0 || ym == '0) begin
              res_x <= xm;
              res_wipe <= 1'b1;
              state <= FINISH;
            end else if (x_single) begin
              res_x <= xm;
              one_pass <= 1'b1;
              state <= YPASS;
            end else begin
              res_x <= '0;
              one_pass <= y_single;
              state <= XPASS;
            end
          end
        end
        XPASS: begin
          res_x <= keep_next;
          cnt <= cnt + CW'(1);
          if (last) begin
            cnt <= '0;
            if (keep_next == '0) begin
              res_wipe <= 1'b1;
              state <= FINISH;
            end else if (one_pass) begin
              res_ent <= 1'b1;
              state <= FINISH;
            end else begin
              state <= YPASS;
            end
          end
        end
        YPASS: begin
          acc <= acc_next;
          cnt <= cnt + CW'(1);
          if (last) begin
            cnt <= '0;
            res_y <= y_final;
            res_wipe <= (y_final == '0);
            res_ent <= one_pass && (y_final != '0);
            state <= FINISH;
          end
        end
        FINISH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            x_domain_out <= x_port;
            y_domain_out <= y_port;
            wiped_out <= res_wipe;
            entailed <= res_ent;
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (state == IDLE) |-> (cnt == '0))
    else $error("Pass counter is not at zero while idle.");

  assert property (@(posedge clk) disable iff (rst) $rose(out_valid) |-> $past(state) == FINISH)
    else $error("Result appeared without a finished filter.");

  assert property (@(posedge clk) disable iff (rst) out_valid |-> !(wiped_out && entailed))
    else $error("Result is both wiped out and entailed.");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && wiped_out) |-> (x_domain_out == '0 || y_domain_out == '0))
    else $error("Wipeout reported with two nonempty domains.");

  assert property (@(posedge clk) disable iff (rst) add_cmd.en |-> (state == IDLE))
    else $error("Add command issued while the rows are rotating.");

endmodule

// File: rtl/binary_table_arc_consistency.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary table arc consistency
// Keeps a bit relation between the value indices of two variables and prunes
// their domains on request.
// ----------------------------------------------------------------------------
// Input transactions are taken on in_valid while in_stall is low. An add
// transaction (op 0) sets relation bits in the cycle it is taken and gives no
// result; the block can take the next transaction in the following cycle.
// A filter transaction (op 1) gives one result transaction on out_valid,
// taken while out_stall is low. Its rows rotate through the chain of row
// cells past the head cell, one row a cycle, in an x pass followed by a y
// pass. The x pass is skipped when the x domain holds a single value, the
// y pass when only the y domain does; when a domain is empty, neither pass
// runs and the filter reports a wipeout with the domains unchanged. in_stall
// is high for the whole filter. A result may wait in the output register
// while new transactions are taken; a following filter holds in its final
// cycle until that register is free. support_mode is written through cfg_valid
// and cfg_ready, with cfg_ready always high. Synchronous reset clears the
// relation, sets support_mode, and empties the output register.
// ----------------------------------------------------------------------------
module binary_table_arc_consistency #(
  parameter int DOMAIN_SIZE = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic op,
  input  logic [bta_pkg::IDX_W-1:0] x_index,
  input  logic [bta_pkg::IDX_W-1:0] y_index,
  input  logic x_any,
  input  logic y_any,
  input  logic [bta_pkg::DOM_W-1:0] x_domain,
  input  logic [bta_pkg::DOM_W-1:0] y_domain,
  output logic out_valid,
  input  logic out_stall,
  output logic [bta_pkg::DOM_W-1:0] x_domain_out,
  output logic [bta_pkg::DOM_W-1:0] y_domain_out,
  output logic wiped_out,
  output logic entailed
);

  logic support_mode;
  logic shift;
  bta_pkg::add_cmd_t add_cmd;
  logic [DOMAIN_SIZE-1:0] rows [DOMAIN_SIZE];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      support_mode <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      support_mode <= cfg_data;
    end
  end

  for (genvar i = 0; i < DOMAIN_SIZE; i++) begin : g_cell
    localparam int NEXT = (i + 1) % DOMAIN_SIZE;
    bta_cell #(
      .WIDTH(DOMAIN_SIZE),
      .ROW_INDEX(i)
    ) u_cell (
      .clk(clk),
      .rst(rst),
      .shift(shift),
      .add_cmd(add_cmd),
      .row_in(rows[NEXT]),
      .row_out(rows[i])
    );
  end

  bta_seq #(
    .DOMAIN_SIZE(DOMAIN_SIZE)
  ) u_seq (
    .clk(clk),
    .rst(rst),
    .support_mode(support_mode),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .x_index(x_index),
    .y_index(y_index),
    .x_any(x_any),
    .y_any(y_any),
    .x_domain(x_domain),
    .y_domain(y_domain),
    .head_row(rows[0]),
    .shift(shift),
    .add_cmd(add_cmd),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .x_domain_out(x_domain_out),
    .y_domain_out(y_domain_out),
    .wiped_out(wiped_out),
    .entailed(entailed)
  );

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Binary table arc consistency testbench
// Builds the value relation with add transactions and checks every filter
// result against a cycle-free predictor kept in step with accepted
// transactions. Runs directed cases in both modes, random phases with sender
// gaps, receiver stalls and one long output hold-off, then a full table.
// ----------------------------------------------------------------------------
module tb;

  localparam int DSIZE = 16;
  localparam int DRAIN_CYCLES = 2 * DSIZE + 8;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 440;
  localparam int CYCLE_LIMIT = 500000;
  localparam int REPORT_LIMIT = 200;

  typedef struct packed {
    logic op;
    logic [bta_pkg::IDX_W-1:0] x_index;
    logic [bta_pkg::IDX_W-1:0] y_index;
    logic x_any;
    logic y_any;
    logic [bta_pkg::DOM_W-1:0] x_domain;
    logic [bta_pkg::DOM_W-1:0] y_domain;
  } arc_item_t;

  typedef struct packed {
    logic [bta_pkg::DOM_W-1:0] x_dom;
    logic [bta_pkg::DOM_W-1:0] y_dom;
    logic wipe;
    logic ent;
  } prune_result_t;

  logic clk;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic op = bta_pkg::OP_ADD;
  logic [bta_pkg::IDX_W-1:0] x_index = '0;
  logic [bta_pkg::IDX_W-1:0] y_index = '0;
  logic x_any = 1'b0;
  logic y_any = 1'b0;
  logic [bta_pkg::DOM_W-1:0] x_domain = '0;
  logic [bta_pkg::DOM_W-1:0] y_domain = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [bta_pkg::DOM_W-1:0] x_domain_out;
  logic [bta_pkg::DOM_W-1:0] y_domain_out;
  logic wiped_out;
  logic entailed;

  logic [bta_pkg::DOM_W-1:0] rel_rows [DSIZE];
  logic support_pred = 1'b1;
  prune_result_t pruned_q [$];

  int fail_count = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  binary_table_arc_consistency #(
    .DOMAIN_SIZE(DSIZE)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .x_index(x_index),
    .y_index(y_index),
    .x_any(x_any),
    .y_any(y_any),
    .x_domain(x_domain),
    .y_domain(y_domain),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .x_domain_out(x_domain_out),
    .y_domain_out(y_domain_out),
    .wiped_out(wiped_out),
    .entailed(entailed)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic is_single(input logic [bta_pkg::DOM_W-1:0] d);
    return (d != '0) && ((d & (d - 1'b1)) == '0);
  endfunction

  function automatic logic [bta_pkg::DOM_W-1:0] keep_rows(
      input logic [bta_pkg::DOM_W-1:0] xd, input logic [bta_pkg::DOM_W-1:0] yd);
    logic [bta_pkg::DOM_W-1:0] kept;
    int i;
    kept = '0;
    for (i = 0; i < DSIZE; i++) begin
      if (xd[i]) begin
        kept[i] = support_pred ? |(rel_rows[i] & yd) : |(~rel_rows[i] & yd);
      end
    end
    return kept;
  endfunction

  function automatic logic [bta_pkg::DOM_W-1:0] keep_cols(
      input logic [bta_pkg::DOM_W-1:0] yd, input logic [bta_pkg::DOM_W-1:0] xd);
    logic [bta_pkg::DOM_W-1:0] kept;
    int i;
    int j;
    kept = '0;
    for (j = 0; j < DSIZE; j++) begin
      if (yd[j]) begin
        for (i = 0; i < DSIZE; i++) begin
          if (xd[i] && rel_rows[i][j] == support_pred) kept[j] = 1'b1;
        end
      end
    end
    return kept;
  endfunction

  function automatic prune_result_t predict_prune(input logic [bta_pkg::DOM_W-1:0] xd,
                                                  input logic [bta_pkg::DOM_W-1:0] yd);
    prune_result_t r;
    r.x_dom = xd;
    r.y_dom = yd;
    r.wipe = 1'b0;
    r.ent = 1'b0;
    if (xd == '0 || yd == '0) begin
      r.wipe = 1'b1;
    end else if (is_single(xd)) begin
      r.y_dom = keep_cols(yd, xd);
      r.wipe = (r.y_dom == '0);
      r.ent = !r.wipe;
    end else if (is_single(yd)) begin
      r.x_dom = keep_rows(xd, yd);
      r.wipe = (r.x_dom == '0);
      r.ent = !r.wipe;
    end else begin
      r.x_dom = keep_rows(xd, yd);
      if (r.x_dom == '0) begin
        r.wipe = 1'b1;
      end else begin
        r.y_dom = keep_cols(yd, r.x_dom);
        r.wipe = (r.y_dom == '0);
      end
    end
    return r;
  endfunction

  function automatic void apply_item(input arc_item_t it);
    int i;
    if (it.op == bta_pkg::OP_FILTER) begin
      pruned_q.push_back(predict_prune(it.x_domain, it.y_domain));
    end else begin
      for (i = 0; i < DSIZE; i++) begin
        if (it.x_any || i == int'(it.x_index)) begin
          rel_rows[i] = it.y_any ? '1 : (rel_rows[i] | (16'd1 << it.y_index));
        end
      end
    end
  endfunction

  function automatic logic [bta_pkg::DOM_W-1:0] rand_domain();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(15))
      0: return '0;
      1, 2: return 16'd1 << a[3:0];
      3: return '1;
      4, 5: return a[15:0] & b[15:0];
      6, 7: return a[15:0] | b[15:0];
      default: return a[15:0];
    endcase
  endfunction

  function automatic arc_item_t make_add(input int xi, input int yi, input logic xa,
                                         input logic ya);
    arc_item_t it;
    it.op = bta_pkg::OP_ADD;
    it.x_index = xi[bta_pkg::IDX_W-1:0];
    it.y_index = yi[bta_pkg::IDX_W-1:0];
    it.x_any = xa;
    it.y_any = ya;
    it.x_domain = rand_domain();
    it.y_domain = rand_domain();
    return it;
  endfunction

  function automatic arc_item_t make_filter(input logic [bta_pkg::DOM_W-1:0] xd,
                                            input logic [bta_pkg::DOM_W-1:0] yd);
    arc_item_t it;
    logic [31:0] r;
    r = $urandom;
    it.op = bta_pkg::OP_FILTER;
    it.x_index = r[3:0];
    it.y_index = r[7:4];
    it.x_any = r[8];
    it.y_any = r[9];
    it.x_domain = xd;
    it.y_domain = yd;
    return it;
  endfunction

  function automatic arc_item_t random_item();
    logic [31:0] r;
    r = $urandom;
    if ($urandom_range(99) < 14) begin
      case ($urandom_range(49))
        0: return make_add(int'(r[3:0]), int'(r[7:4]), 1'b1, 1'b0);
        1: return make_add(int'(r[3:0]), int'(r[7:4]), 1'b0, 1'b1);
        default: return make_add(int'(r[3:0]), int'(r[7:4]), 1'b0, 1'b0);
      endcase
    end
    return make_filter(rand_domain(), rand_domain());
  endfunction

  task automatic send_item(input arc_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    x_index <= it.x_index;
    y_index <= it.y_index;
    x_any <= it.x_any;
    y_any <= it.y_any;
    x_domain <= it.x_domain;
    y_domain <= it.y_domain;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    apply_item(it);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pruned_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    support_pred = mode;
  endtask

  task automatic check_field(input string name, input logic [bta_pkg::DOM_W-1:0] exp_v,
                             input logic [bta_pkg::DOM_W-1:0] act_v);
    if (exp_v !== act_v) begin
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
        $display("%0t: %s expected %h actual %h", $time, name, exp_v, act_v);
      end
    end
  endtask

  task automatic check_result();
    prune_result_t exp_r;
    if (pruned_q.size() == 0) begin
      fail_count++;
      $display("%0t: unexpected result transaction, expected none actual %h %h %b %b",
               $time, x_domain_out, y_domain_out, wiped_out, entailed);
    end else begin
      exp_r = pruned_q.pop_front();
      check_field("x_domain_out", exp_r.x_dom, x_domain_out);
      check_field("y_domain_out", exp_r.y_dom, y_domain_out);
      check_field("wiped_out", {15'd0, exp_r.wipe}, {15'd0, wiped_out});
      check_field("entailed", {15'd0, exp_r.ent}, {15'd0, entailed});
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) check_result();
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_requests != hold_served) begin
        hold_served <= hold_requests;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic run_random(input int count);
    int n;
    for (n = 0; n < count; n++) send_item(random_item());
    drain();
  endtask

  task automatic test_empty_domains();
    write_mode(1'b1);
    send_item(make_filter(16'h0000, 16'hFFFF));
    send_item(make_filter(16'hFFFF, 16'h0000));
    send_item(make_filter(16'h0000, 16'h0000));
    send_item(make_filter(16'hFFFF, 16'hFFFF));
    send_item(make_filter(16'h0001, 16'h8000));
    drain();
  endtask

  task automatic test_tuple_forms();
    send_item(make_add(0, 0, 1'b0, 1'b0));
    send_item(make_add(15, 15, 1'b0, 1'b0));
    send_item(make_add(3, 0, 1'b0, 1'b1));
    send_item(make_add(0, 9, 1'b1, 1'b0));
    send_item(make_filter(16'h0001, 16'hFFFF));
    send_item(make_filter(16'hFFFF, 16'h8000));
    send_item(make_filter(16'h0080, 16'h0010));
    send_item(make_filter(16'hFFFF, 16'hFFFF));
    send_item(make_filter(16'h8008, 16'h0201));
    drain();
  endtask

  task automatic test_conflict_mode();
    write_mode(1'b0);
    send_item(make_filter(16'hFFFF, 16'hFFFF));
    send_item(make_filter(16'h0008, 16'hFFFF));
    send_item(make_filter(16'hFFFF, 16'h0200));
    send_item(make_filter(16'h0006, 16'h0FF0));
    send_item(make_filter(16'h0000, 16'h0005));
    drain();
  endtask

  task automatic test_random_support();
    write_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_random_sender_gaps();
    write_mode(1'b0);
    send_idle_pct = 52;
    recv_stall_pct = 0;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_output_backpressure();
    write_mode(1'b1);
    send_idle_pct = 0;
    recv_stall_pct = 52;
    hold_requests <= hold_requests + 1;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_random_both_idle();
    write_mode(1'b0);
    send_idle_pct = 26;
    recv_stall_pct = 26;
    run_random(PHASE_ITEMS);
  endtask

  task automatic test_full_relation();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_item(make_add(0, 0, 1'b1, 1'b1));
    send_item(make_filter(16'hFFFF, 16'hFFFF));
    drain();
    write_mode(1'b1);
    send_item(make_filter(16'hFFFF, 16'hFFFF));
    send_item(make_filter(16'h0100, 16'h00F0));
    drain();
  endtask

  initial begin
    for (int i = 0; i < DSIZE; i++) rel_rows[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_domains();
    test_tuple_forms();
    test_conflict_mode();
    test_random_support();
    test_random_sender_gaps();
    test_output_backpressure();
    test_random_both_idle();
    test_full_relation();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
